/* rtl/sgh_pkg.sv */
// Shared types, constants and codes for the swiss group hash table.
// No dependencies; sgh_ifs and the top level import this package.
package sgh_pkg;

    // Fixed geometry and port field widths
    localparam int SLOTS_PER_GROUP = 16;
    localparam int SLOT_W          = $clog2(SLOTS_PER_GROUP);
    localparam int CTRL_W          = 8;
    localparam int TAG_W           = 7;
    localparam int ACTION_W        = 2;
    localparam int KEY_PORT_W      = 32;
    localparam int HASH_W          = 64;
    localparam int ENTRY_PORT_W    = 32;
    localparam int STATUS_W        = 2;
    localparam int LIVE_W          = 9;
    localparam int CFG_W           = 3;

    // Defaults for the top-level parameters
    localparam int DEF_GROUP_COUNT = 16;
    localparam int DEF_KEY_WIDTH   = 32;
    localparam int DEF_ENTRY_WIDTH = 32;

    // Control byte encodings
    localparam logic [CTRL_W-1:0] CTRL_EMPTY    = 8'hFF;
    localparam logic [CTRL_W-1:0] CTRL_TOMB     = 8'h80;
    localparam logic [CTRL_W-1:0] TAG_MASK      = 8'h7F;
    localparam logic [CTRL_W-1:0] CTRL_FREE_BIT = 8'h80;
    localparam int                GROUP_SHIFT   = 7;

    // Reset value of the group count register
    localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

    // Request actions
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

endpackage

/* rtl/sgh_ifs.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on sgh_pkg for the field widths.
interface sgh_req_if;
    import sgh_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [ACTION_W-1:0]     action;
    logic [KEY_PORT_W-1:0]   key;
    logic [HASH_W-1:0]       key_hash;
    logic [ENTRY_PORT_W-1:0] entry;
    modport source (output valid, action, key, key_hash, entry, input ready);
    modport sink   (input valid, action, key, key_hash, entry, output ready);
endinterface

interface sgh_rsp_if;
    import sgh_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [ENTRY_PORT_W-1:0] found_entry;
    logic [LIVE_W-1:0]       live_count;
    modport source (output valid, status, found_entry, live_count, input ready);
    modport sink   (input valid, status, found_entry, live_count, output ready);
endinterface

/* rtl/sgh_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sgh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one row
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one row, hold the data while not reading
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/swiss_group_hash_table.sv */
// Top level of the swiss group hash table engine: probe sequencer and result register.
// Depends on sgh_pkg, sgh_ifs (sgh_req_if, sgh_rsp_if) and sgh_ram.
//
//   channel   | dir | beat contents
//   ----------+-----+---------------------------------------------
//   i_req     | in  | action, key, key_hash, entry
//   o_rsp     | out | status, found_entry, live_count
//   i_cfg_*   | in  | group_count_log2 (write only)
//
// A request is accepted, then each probed group is read and matched (S_READ,
// S_CHECK), and the result is posted (S_RESP); an insert into a free slot adds
// a re-read and a write of the target row (S_FIX_RD, S_FIX_WR).
// The probe loop reads one control row and one key/entry row per group.
// After reset the control store is swept to empty, one group per cycle,
// before the first request is taken.
// A finished result waits in the output register; the next request is taken
// meanwhile and stalls only when its own result is ready.
module swiss_group_hash_table #(
    parameter int GROUP_COUNT = sgh_pkg::DEF_GROUP_COUNT,
    parameter int KEY_WIDTH   = sgh_pkg::DEF_KEY_WIDTH,
    parameter int ENTRY_WIDTH = sgh_pkg::DEF_ENTRY_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [sgh_pkg::CFG_W-1:0] i_cfg_wdata,
    sgh_req_if.sink                   i_req,
    sgh_rsp_if.source                 o_rsp
);
    import sgh_pkg::*;

    localparam int GW       = $clog2(GROUP_COUNT);
    localparam int LANE_W   = KEY_WIDTH + ENTRY_WIDTH;
    localparam int CROW_W   = SLOTS_PER_GROUP * CTRL_W;
    localparam int KVROW_W  = SLOTS_PER_GROUP * LANE_W;
    localparam int TOTAL    = GROUP_COUNT * SLOTS_PER_GROUP;
    localparam int CNT_W    = $clog2(TOTAL + 1);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_READ   = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_FIX_RD = 7'b0010000,
        S_FIX_WR = 7'b0100000,
        S_RESP   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0]        r_cfg;
    logic [GW-1:0]           r_clr;
    logic [GW-1:0]           r_group;
    logic [GW-1:0]           r_visit;
    logic [ACTION_W-1:0]     r_action;
    logic [KEY_WIDTH-1:0]    r_key;
    logic [TAG_W-1:0]        r_tag;
    logic [ENTRY_WIDTH-1:0]  r_entry;
    logic                    r_free_v;
    logic [GW-1:0]           r_free_grp;
    logic [SLOT_W-1:0]       r_free_slot;
    logic [CNT_W-1:0]        r_count;
    logic [STATUS_W-1:0]     r_status;
    logic [ENTRY_WIDTH-1:0]  r_found;
    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_out_status;
    logic [ENTRY_PORT_W-1:0] r_out_found;
    logic [LIVE_W-1:0]       r_out_live;

    logic [CFG_W-1:0]   lg_eff;
    logic [GW-1:0]      mask;
    logic               req_beat;
    logic [63:0]        key_ext;
    logic [63:0]        entry_ext;
    logic [GW-1:0]      start_grp;

    logic               ctrl_we, ctrl_re, kv_we, kv_re;
    logic [GW-1:0]      ctrl_waddr, rd_addr;
    logic [CROW_W-1:0]  ctrl_wdata, ctrl_rdata;
    logic [KVROW_W-1:0] kv_wdata, kv_rdata;

    logic [SLOTS_PER_GROUP-1:0] hit_vec, empty_vec, free_vec;
    logic                       hit_any, has_empty, free_any;
    logic [SLOT_W-1:0]          hit_slot, free_slot;
    logic [ENTRY_WIDTH-1:0]     hit_entry;
    logic [CTRL_W-1:0]          del_code;
    logic                       last_group;
    logic                       out_free;
    logic [63:0]                found_ext;
    logic [31:0]                live_ext;

    // Clamp the group count register and build the probe mask
    always_comb begin
        lg_eff = (r_cfg == '0) ? CFG_W'(1) : r_cfg;
        for (int i = 0; i < GW; i++) begin
            mask[i] = (i < int'(lg_eff));
        end
    end

    assign req_beat  = i_req.valid && i_req.ready;
    assign key_ext   = 64'(i_req.key);
    assign entry_ext = 64'(i_req.entry);
    assign start_grp = i_req.key_hash[GROUP_SHIFT +: GW] & mask;

    // Match the current group row on tag and key
    always_comb begin
        hit_slot  = '0;
        free_slot = '0;
        hit_entry = '0;
        for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
            hit_vec[s] = (ctrl_rdata[s*CTRL_W +: CTRL_W] == {1'b0, r_tag})
                      && (kv_rdata[s*LANE_W +: KEY_WIDTH] == r_key);
            empty_vec[s] = (ctrl_rdata[s*CTRL_W +: CTRL_W] == CTRL_EMPTY);
            free_vec[s]  = ((ctrl_rdata[s*CTRL_W +: CTRL_W] & CTRL_FREE_BIT) != '0);
        end
        for (int s = SLOTS_PER_GROUP - 1; s >= 0; s--) begin
            if (hit_vec[s]) begin
                hit_slot  = SLOT_W'(s);
                hit_entry = kv_rdata[s*LANE_W + KEY_WIDTH +: ENTRY_WIDTH];
            end
            if (free_vec[s]) begin
                free_slot = SLOT_W'(s);
            end
        end
        hit_any    = |hit_vec;
        has_empty  = |empty_vec;
        free_any   = |free_vec;
        del_code   = has_empty ? CTRL_EMPTY : CTRL_TOMB;
        last_group = (r_visit == mask);
    end

    // Memory read port: probe rows or the insert target row
    always_comb begin
        ctrl_re = (r_state == S_READ) || (r_state == S_FIX_RD);
        kv_re   = ctrl_re;
        rd_addr = (r_state == S_FIX_RD) ? r_free_grp : r_group;
    end

    // Memory write port: clearing sweep, delete, insert
    always_comb begin
        ctrl_we    = 1'b0;
        ctrl_waddr = r_group;
        ctrl_wdata = ctrl_rdata;
        kv_we      = 1'b0;
        kv_wdata   = kv_rdata;
        case (r_state)
            S_CLEAR: begin
                ctrl_we    = 1'b1;
                ctrl_waddr = r_clr;
                ctrl_wdata = {SLOTS_PER_GROUP{CTRL_EMPTY}};
            end
            S_CHECK: begin
                ctrl_we = hit_any && (r_action == ACT_DELETE);
                ctrl_wdata[hit_slot*CTRL_W +: CTRL_W] = del_code;
            end
            S_FIX_WR: begin
                ctrl_we    = 1'b1;
                kv_we      = 1'b1;
                ctrl_waddr = r_free_grp;
                ctrl_wdata[r_free_slot*CTRL_W +: CTRL_W] = {1'b0, r_tag};
                kv_wdata[r_free_slot*LANE_W +: LANE_W]   = {r_entry, r_key};
            end
            default: begin
                ctrl_we = 1'b0;
            end
        endcase
    end

    sgh_ram #(.WIDTH(CROW_W), .DEPTH(GROUP_COUNT)) u_ctrl_ram (
        .i_clk   (i_clk),
        .i_we    (ctrl_we),
        .i_waddr (ctrl_waddr),
        .i_wdata (ctrl_wdata),
        .i_re    (ctrl_re),
        .i_raddr (rd_addr),
        .o_rdata (ctrl_rdata)
    );

    sgh_ram #(.WIDTH(KVROW_W), .DEPTH(GROUP_COUNT)) u_kv_ram (
        .i_clk   (i_clk),
        .i_we    (kv_we),
        .i_waddr (ctrl_waddr),
        .i_wdata (kv_wdata),
        .i_re    (kv_re),
        .i_raddr (rd_addr),
        .o_rdata (kv_rdata)
    );

    assign out_free = !r_out_valid || o_rsp.ready;

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == GW'(GROUP_COUNT - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (req_beat) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (hit_any) begin
                    n_state = S_RESP;
                end else if (has_empty || last_group) begin
                    if ((r_action == ACT_INSERT) && (r_free_v || free_any)) begin
                        n_state = S_FIX_RD;
                    end else begin
                        n_state = S_RESP;
                    end
                end else begin
                    n_state = S_READ;
                end
            end
            S_FIX_RD: begin
                n_state = S_FIX_WR;
            end
            S_FIX_WR: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cfg       <= CFG_RESET;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_free_v    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (req_beat) r_free_v <= 1'b0;
            else if (r_state == S_CHECK && !r_free_v && free_any) r_free_v <= 1'b1;
            if (r_state == S_CHECK && hit_any && r_action == ACT_DELETE
                && r_count != '0) begin
                r_count <= r_count - 1'b1;
            end else if (r_state == S_FIX_WR) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == S_RESP && out_free) r_out_valid <= 1'b1;
            else if (o_rsp.ready) r_out_valid <= 1'b0;
        end
    end

    // Request capture and probe advance
    always_ff @(posedge i_clk) begin
        if (req_beat) begin
            r_action <= i_req.action;
            r_key    <= key_ext[KEY_WIDTH-1:0];
            r_entry  <= entry_ext[ENTRY_WIDTH-1:0];
            r_tag    <= i_req.key_hash[TAG_W-1:0];
            r_group  <= start_grp;
            r_visit  <= '0;
        end else if (r_state == S_CHECK) begin
            r_group <= (r_group + 1'b1) & mask;
            r_visit <= r_visit + 1'b1;
            if (!r_free_v && free_any) begin
                r_free_grp  <= r_group;
                r_free_slot <= free_slot;
            end
        end
    end

    // Result of the request
    always_ff @(posedge i_clk) begin
        if (r_state == S_CHECK) begin
            r_found  <= '0;
            r_status <= ST_MISSING;
            if (hit_any) begin
                case (r_action)
                    ACT_SEARCH: begin
                        r_status <= ST_DONE;
                        r_found  <= hit_entry;
                    end
                    ACT_INSERT: begin
                        r_status <= ST_PRESENT;
                        r_found  <= hit_entry;
                    end
                    ACT_DELETE: begin
                        r_status <= ST_DONE;
                    end
                    default: begin
                        r_status <= ST_MISSING;
                    end
                endcase
            end else if (r_action == ACT_INSERT) begin
                r_status <= ST_FULL;
            end
        end else if (r_state == S_FIX_WR) begin
            r_status <= ST_DONE;
        end
    end

    assign found_ext = 64'(r_found);
    assign live_ext  = 32'(r_count);

    // Output register, loaded when the slot is free
    always_ff @(posedge i_clk) begin
        if (r_state == S_RESP && out_free) begin
            r_out_status <= r_status;
            r_out_found  <= found_ext[ENTRY_PORT_W-1:0];
            r_out_live   <= live_ext[LIVE_W-1:0];
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_entry = r_out_found;
    assign o_rsp.live_count  = r_out_live;

    // Probe never walks past the groups in use
    a_visit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_visit <= mask))
        else $error("probe visited more groups than in use");

    // Occupancy never exceeds the slot count
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TOTAL))
        else $error("live count above table size");

    // An accepted request starts a row read
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_beat |=> (r_state == S_READ))
        else $error("accepted request did not start probing");

    // Insert write only with a recorded free slot
    a_fix_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX_WR) |-> r_free_v)
        else $error("insert without free slot");

endmodule
